// ----- hw/rtl/mgbn_pkg.sv -----
package mgbn_pkg;

    // default sizes of the storage
    localparam int CLIENTS_DEF    = 4;
    localparam int SEQ_SPACE_DEF  = 64;
    localparam int WINDOW_MAX_DEF = 8;

    // fixed field widths
    localparam int NC_W   = 3;
    localparam int PC_W   = 7;
    localparam int WS_W   = 4;
    localparam int FUNC_W = 2;
    localparam int CID_W  = 2;
    localparam int SEQ_W  = 6;
    localparam int KIND_W = 2;
    localparam int BASE_W = 7;
    localparam int IDX_W  = 2;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_NUM_CLIENTS  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_PACKET_COUNT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd2;

    localparam logic [NC_W-1:0] NUM_CLIENTS_RST  = 3'd2;
    localparam logic [PC_W-1:0] PACKET_COUNT_RST = 7'd10;
    localparam logic [WS_W-1:0] WINDOW_SIZE_RST  = 4'd4;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_START   = 2'd0,
        FUNC_ACK     = 2'd1,
        FUNC_TIMEOUT = 2'd2,
        FUNC_UNKNOWN = 2'd3
    } t_func;

    typedef enum logic [KIND_W-1:0] {
        KIND_SEND   = 2'd0,
        KIND_RESEND = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    // sequencer step addresses
    typedef enum logic [3:0] {
        ST_WAIT,
        ST_DISP,
        ST_ISACK,
        ST_ACK,
        ST_SLINIT,
        ST_SLTEST,
        ST_RSINIT,
        ST_RSTEST,
        ST_FILL,
        ST_SEND,
        ST_STAT
    } t_step;

    typedef enum logic [3:0] {
        OP_WAIT,
        OP_DISP,
        OP_ISACK,
        OP_ACK,
        OP_SLINIT,
        OP_SLTEST,
        OP_RSINIT,
        OP_RSTEST,
        OP_FILL,
        OP_SEND,
        OP_STAT
    } t_uop;

    // one control word: operation, result emission with kind and last flag, branch targets
    typedef struct packed {
        t_uop  op;
        logic  emit;
        t_kind kind;
        logic  last;
        t_step nxt_t;
        t_step nxt_f;
    } t_uword;

    function automatic t_uword ucode(input t_step st);
        t_uword w;
        case (st)
            ST_WAIT:   w = '{OP_WAIT,   1'b0, KIND_SEND,   1'b0, ST_DISP,   ST_DISP};
            ST_DISP:   w = '{OP_DISP,   1'b0, KIND_SEND,   1'b0, ST_STAT,   ST_ISACK};
            ST_ISACK:  w = '{OP_ISACK,  1'b0, KIND_SEND,   1'b0, ST_ACK,    ST_SLINIT};
            ST_ACK:    w = '{OP_ACK,    1'b0, KIND_SEND,   1'b0, ST_SLINIT, ST_SLINIT};
            ST_SLINIT: w = '{OP_SLINIT, 1'b0, KIND_SEND,   1'b0, ST_SLTEST, ST_RSINIT};
            ST_SLTEST: w = '{OP_SLTEST, 1'b0, KIND_SEND,   1'b0, ST_RSINIT, ST_SLTEST};
            ST_RSINIT: w = '{OP_RSINIT, 1'b0, KIND_SEND,   1'b0, ST_RSTEST, ST_FILL};
            ST_RSTEST: w = '{OP_RSTEST, 1'b1, KIND_RESEND, 1'b0, ST_FILL,   ST_RSTEST};
            ST_FILL:   w = '{OP_FILL,   1'b0, KIND_SEND,   1'b0, ST_SEND,   ST_STAT};
            ST_SEND:   w = '{OP_SEND,   1'b1, KIND_SEND,   1'b0, ST_FILL,   ST_SEND};
            ST_STAT:   w = '{OP_STAT,   1'b1, KIND_STATUS, 1'b1, ST_WAIT,   ST_WAIT};
            default:   w = '{OP_WAIT,   1'b0, KIND_SEND,   1'b0, ST_WAIT,   ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/multicast_go_back_n_sender.sv -----
// Events: an unknown event yields only its status result; otherwise an ack is recorded if it is
// one, the window slides, a timeout rescans the old window for resends (acked bits skipped)
// and new sequences are sent, then the status result. Flow: one event at a time; the next
// transfer is taken only after the status result, and at most one result per cycle leaves
// through the single output register.
// Reset (sync, active low) clears base, next, all ack bits at once and loads register defaults.
module multicast_go_back_n_sender #(
    parameter int CLIENTS    = mgbn_pkg::CLIENTS_DEF,
    parameter int SEQ_SPACE  = mgbn_pkg::SEQ_SPACE_DEF,
    parameter int WINDOW_MAX = mgbn_pkg::WINDOW_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // event input
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [mgbn_pkg::S_TDATA_W-1:0]  i_s_tdata,   // client_id[1:0], ack_seq[7:2]
    input  logic [mgbn_pkg::FUNC_W-1:0]     i_s_tuser,   // func[1:0]
    // result output
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [mgbn_pkg::M_TDATA_W-1:0]  o_m_tdata,   // dest_client[1:0], send_seq[7:2],
                                                         // window_base[14:8], all_done[15]
    output logic [mgbn_pkg::KIND_W-1:0]     o_m_tuser,   // kind[1:0]
    output logic                            o_m_tlast,   // last
    // register writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mgbn_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [mgbn_pkg::PC_W-1:0]       i_cfg_data
);

    localparam int CIW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int SIW = $clog2(SEQ_SPACE);
    localparam logic [mgbn_pkg::NC_W-1:0] NC_CAP =
        mgbn_pkg::NC_W'((CLIENTS > 7) ? 7 : CLIENTS);
    localparam logic [mgbn_pkg::PC_W-1:0] PC_CAP =
        mgbn_pkg::PC_W'((SEQ_SPACE > 127) ? 127 : SEQ_SPACE);
    localparam logic [mgbn_pkg::WS_W-1:0] WIN_CAP =
        mgbn_pkg::WS_W'((WINDOW_MAX > 15) ? 15 : WINDOW_MAX);

    // configuration
    logic [mgbn_pkg::NC_W-1:0] r_num_clients;
    logic [mgbn_pkg::PC_W-1:0] r_packet_count;
    logic [mgbn_pkg::WS_W-1:0] r_window_size;

    logic [mgbn_pkg::NC_W-1:0] nc_eff;
    logic [mgbn_pkg::PC_W-1:0] pc_eff;
    logic [mgbn_pkg::WS_W-1:0] win_eff;

    // sequencer and datapath
    mgbn_pkg::t_step  r_step, n_step;
    mgbn_pkg::t_uword u;
    mgbn_pkg::t_func  r_func;
    logic [mgbn_pkg::CID_W-1:0]  r_cid;
    logic [mgbn_pkg::SEQ_W-1:0]  r_aseq;
    logic [mgbn_pkg::BASE_W-1:0] r_base;
    logic [mgbn_pkg::BASE_W-1:0] r_old;
    logic [mgbn_pkg::BASE_W-1:0] r_next;
    logic [mgbn_pkg::BASE_W-1:0] r_seq;
    logic [mgbn_pkg::NC_W-1:0]   r_cli;
    logic [SEQ_SPACE-1:0]        r_bmp [CLIENTS];

    logic [mgbn_pkg::BASE_W-1:0] rd_seq;
    logic bit_rd, cli_last, seq_last, fill_ok, ack_ok;
    logic in_acc, slot_free, emit_req, emit_go, hold, cond;

    // output register
    logic                        r_ov;
    mgbn_pkg::t_kind             r_o_kind;
    logic [mgbn_pkg::CID_W-1:0]  r_o_dest;
    logic [mgbn_pkg::SEQ_W-1:0]  r_o_seq;
    logic [mgbn_pkg::BASE_W-1:0] r_o_base;
    logic                        r_o_done;
    logic                        r_o_last;

    always_comb begin
        nc_eff  = (r_num_clients == '0) ? 3'd1 :
                  ((r_num_clients > NC_CAP) ? NC_CAP : r_num_clients);
        pc_eff  = (r_packet_count > PC_CAP) ? PC_CAP : r_packet_count;
        win_eff = (r_window_size == '0) ? 4'd1 :
                  ((r_window_size > WIN_CAP) ? WIN_CAP : r_window_size);
    end

    assign u = mgbn_pkg::ucode(r_step);

    assign o_s_tready  = (u.op == mgbn_pkg::OP_WAIT);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign slot_free   = !r_ov || i_m_tready;

    // condition logic shared by branch and datapath
    always_comb begin
        rd_seq   = (u.op == mgbn_pkg::OP_SLTEST) ? r_base : r_seq;
        bit_rd   = r_bmp[CIW'(r_cli)][SIW'(rd_seq)];
        cli_last = (r_cli == nc_eff - 3'd1);
        seq_last = ({1'b0, r_seq} + 8'd1) == {1'b0, r_next};
        fill_ok  = ({1'b0, r_next} < ({1'b0, r_base} + {4'b0, win_eff})) && (r_next < pc_eff);
        ack_ok   = ({1'b0, r_cid} < nc_eff) && (int'(r_aseq) < SEQ_SPACE);
        emit_req = u.emit && !((u.op == mgbn_pkg::OP_RSTEST) && bit_rd);
        emit_go  = emit_req && slot_free;
    end

    // next step
    always_comb begin
        hold = emit_req && !slot_free;
        cond = 1'b1;
        case (u.op)
            mgbn_pkg::OP_WAIT:   hold = !in_acc;
            mgbn_pkg::OP_DISP:   cond = (r_func == mgbn_pkg::FUNC_UNKNOWN);
            mgbn_pkg::OP_ISACK:  cond = (r_func == mgbn_pkg::FUNC_ACK);
            mgbn_pkg::OP_SLINIT: cond = (r_base < pc_eff);
            mgbn_pkg::OP_SLTEST: cond = !bit_rd || cli_last;
            mgbn_pkg::OP_RSINIT: cond = (r_func == mgbn_pkg::FUNC_TIMEOUT) && (r_base < r_next);
            mgbn_pkg::OP_RSTEST: cond = seq_last && cli_last;
            mgbn_pkg::OP_FILL:   cond = fill_ok;
            mgbn_pkg::OP_SEND:   cond = cli_last;
            default:             cond = 1'b1;
        endcase
        n_step = hold ? r_step : (cond ? u.nxt_t : u.nxt_f);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step         <= mgbn_pkg::ST_WAIT;
            r_num_clients  <= mgbn_pkg::NUM_CLIENTS_RST;
            r_packet_count <= mgbn_pkg::PACKET_COUNT_RST;
            r_window_size  <= mgbn_pkg::WINDOW_SIZE_RST;
        end else begin
            r_step <= n_step;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mgbn_pkg::CFG_NUM_CLIENTS:  r_num_clients  <= i_cfg_data[mgbn_pkg::NC_W-1:0];
                    mgbn_pkg::CFG_PACKET_COUNT: r_packet_count <= i_cfg_data;
                    mgbn_pkg::CFG_WINDOW_SIZE:  r_window_size  <= i_cfg_data[mgbn_pkg::WS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // window state and ack bitmap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_next <= '0;
            for (int c = 0; c < CLIENTS; c++) begin
                r_bmp[c] <= '0;
            end
        end else begin
            case (u.op)
                mgbn_pkg::OP_ACK: begin
                    if (ack_ok) r_bmp[CIW'(r_cid)][SIW'(r_aseq)] <= 1'b1;
                end
                mgbn_pkg::OP_SLTEST: begin
                    if (bit_rd && cli_last) r_base <= r_base + 7'd1;
                end
                mgbn_pkg::OP_SEND: begin
                    if (!hold && cli_last) r_next <= r_next + 7'd1;
                end
                default: ;
            endcase
        end
    end

    // event registers and scan counters
    always_ff @(posedge i_clk) begin
        case (u.op)
            mgbn_pkg::OP_WAIT: begin
                if (in_acc) begin
                    r_func <= mgbn_pkg::t_func'(i_s_tuser);
                    r_cid  <= i_s_tdata[1:0];
                    r_aseq <= i_s_tdata[7:2];
                end
            end
            mgbn_pkg::OP_SLINIT: begin
                r_cli <= '0;
                r_old <= r_base;
            end
            mgbn_pkg::OP_SLTEST: begin
                if (bit_rd && !cli_last) r_cli <= r_cli + 3'd1;
            end
            mgbn_pkg::OP_RSINIT: begin
                // resend range is the window as it stood before the slide
                r_cli <= '0;
                r_seq <= r_old;
            end
            mgbn_pkg::OP_RSTEST: begin
                if (!hold) begin
                    if (seq_last) begin
                        r_seq <= r_old;
                        r_cli <= r_cli + 3'd1;
                    end else begin
                        r_seq <= r_seq + 7'd1;
                    end
                end
            end
            mgbn_pkg::OP_FILL: r_cli <= '0;
            mgbn_pkg::OP_SEND: begin
                if (!hold) r_cli <= cli_last ? '0 : r_cli + 3'd1;
            end
            default: ;
        endcase
    end

    // output register; base is already final when any result is built
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit_go) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_o_kind <= u.kind;
            r_o_last <= u.last;
            r_o_base <= r_base;
            r_o_done <= (r_base >= pc_eff);
            case (u.op)
                mgbn_pkg::OP_STAT: begin
                    r_o_dest <= '0;
                    r_o_seq  <= '0;
                end
                mgbn_pkg::OP_SEND: begin
                    r_o_dest <= r_cli[mgbn_pkg::CID_W-1:0];
                    r_o_seq  <= r_next[mgbn_pkg::SEQ_W-1:0];
                end
                default: begin
                    r_o_dest <= r_cli[mgbn_pkg::CID_W-1:0];
                    r_o_seq  <= r_seq[mgbn_pkg::SEQ_W-1:0];
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {r_o_done, r_o_base, r_o_seq, r_o_dest};
    assign o_m_tuser  = r_o_kind;
    assign o_m_tlast  = r_o_last;

endmodule

// ----- hw/rtl/mgbn_checker.sv -----
module mgbn_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [mgbn_pkg::M_TDATA_W-1:0] o_m_tdata,
    input logic [mgbn_pkg::KIND_W-1:0]    o_m_tuser,
    input logic                           o_m_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // no new event is taken while an event's results are still pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("event taken before status of previous event");

    // tlast marks exactly the status result
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tuser == mgbn_pkg::KIND_STATUS) == o_m_tlast))
        else $error("tlast and status kind disagree");

    // status carries no destination and no sequence
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> (o_m_tdata[7:0] == 8'd0))
        else $error("status result with nonzero dest or seq");

endmodule

bind multicast_go_back_n_sender mgbn_checker u_mgbn_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
